@@ hw/rtl/dct8_pkg.sv @@
`timescale 1ns / 1ps

package dct8_pkg;

  // default sample width and headroom kept above it inside the datapath
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int GUARD_BITS      = 8;

  // register stages in each transform path
  localparam int PIPE_DEPTH = 8;

  // Q2.14 constants: unsigned 16 bit, multiply rounds by adding half an lsb
  localparam int KW      = 16;
  localparam int Q_FRAC  = 14;
  localparam int Q_ROUND = 8192;

  localparam logic [KW-1:0] K_SQRT2   = 16'd23170;
  localparam logic [KW-1:0] K_HALF    = 16'd8192;
  localparam logic [KW-1:0] K_QUARTER = 16'd4096;
  localparam logic [KW-1:0] K_F4_SEC0 = 16'd2217;
  localparam logic [KW-1:0] K_F4_SEC1 = 16'd5352;
  localparam logic [KW-1:0] K_I4_SEC0 = 16'd8867;
  localparam logic [KW-1:0] K_I4_SEC1 = 16'd21407;

  // 8-point secants, full for the inverse, halved for the forward
  localparam logic [KW-1:0] SEC_INV [4] = '{16'd8352, 16'd9852, 16'd14745, 16'd41991};
  localparam logic [KW-1:0] SEC_FWD [4] = '{16'd4176, 16'd4926, 16'd7373, 16'd20995};

endpackage

@@ hw/rtl/dct8_fwd.sv @@
`timescale 1ns / 1ps

// Forward 8-point DCT path, eight register stages, one beat per cycle.
module dct8_fwd #(
  parameter int IW = dct8_pkg::SAMPLE_BITS_DEF + dct8_pkg::GUARD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] x [8],
  output logic                 out_valid,
  output logic signed [IW-1:0] y [8]
);

  localparam int PW = IW + dct8_pkg::KW + 1;

  // constant multiply, floor((v*c + half) / 2^14)
  function automatic logic signed [IW-1:0] qmul(input logic signed [IW-1:0] v,
                                                input logic [dct8_pkg::KW-1:0] c);
    logic signed [PW-1:0] p;
    p = PW'(v) * PW'($signed({1'b0, c}));
    p = p + PW'(dct8_pkg::Q_ROUND);
    return p[IW+dct8_pkg::Q_FRAC-1:dct8_pkg::Q_FRAC];
  endfunction

  logic [dct8_pkg::PIPE_DEPTH-1:0] vld_r;

  logic signed [IW-1:0] ps_r [4], ps_nxt [4];
  logic signed [IW-1:0] pd_r [4], pd_nxt [4];
  logic signed [IW-1:0] g_r [8], g_nxt [8];
  logic signed [IW-1:0] s03_r [2], s03_nxt [2];
  logic signed [IW-1:0] s12_r [2], s12_nxt [2];
  logic signed [IW-1:0] d03_r [2], d03_nxt [2];
  logic signed [IW-1:0] d12_r [2], d12_nxt [2];
  logic signed [IW-1:0] t0_r [2], t0_nxt [2];
  logic signed [IW-1:0] t1_r [2], t1_nxt [2];
  logic signed [IW-1:0] ss_r [2], ss_nxt [2];
  logic signed [IW-1:0] sd_r [2], sd_nxt [2];
  logic signed [IW-1:0] dif5_r [2], dif5_nxt [2];
  logic signed [IW-1:0] sm5_r [2], sm5_nxt [2];
  logic signed [IW-1:0] o0_5_r [2], o0_5_nxt [2];
  logic signed [IW-1:0] o2_5_r [2], o2_5_nxt [2];
  logic signed [IW-1:0] m6_r [2], m6_nxt [2];
  logic signed [IW-1:0] dif6_r [2], dif6_nxt [2];
  logic signed [IW-1:0] o0_6_r [2], o0_6_nxt [2];
  logic signed [IW-1:0] o2_6_r [2], o2_6_nxt [2];
  logic signed [IW-1:0] mf0_6_r, mf0_6_nxt;
  logic signed [IW-1:0] e7_r [4], e7_nxt [4];
  logic signed [IW-1:0] f7_r [4], f7_nxt [4];
  logic signed [IW-1:0] mf0_7_r, mf0_7_nxt;
  logic signed [IW-1:0] y_r [8], y_nxt [8];

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[dct8_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_comb begin
    // stage 1: mirrored sums and differences
    for (int i = 0; i < 4; i++) begin
      ps_nxt[i] = x[i] + x[7-i];
      pd_nxt[i] = x[i] - x[7-i];
    end
    // stage 2: halve the sums, secant-weight the differences
    for (int i = 0; i < 4; i++) begin
      g_nxt[i]   = qmul(ps_r[i], dct8_pkg::K_HALF);
      g_nxt[4+i] = qmul(pd_r[i], dct8_pkg::SEC_FWD[i]);
    end
    // stages 3 to 7: two forward 4-point transforms side by side
    for (int j = 0; j < 2; j++) begin
      s03_nxt[j]  = g_r[4*j] + g_r[4*j+3];
      s12_nxt[j]  = g_r[4*j+1] + g_r[4*j+2];
      d03_nxt[j]  = g_r[4*j] - g_r[4*j+3];
      d12_nxt[j]  = g_r[4*j+1] - g_r[4*j+2];

      t0_nxt[j]   = qmul(d03_r[j], dct8_pkg::K_F4_SEC0);
      t1_nxt[j]   = qmul(d12_r[j], dct8_pkg::K_F4_SEC1);
      ss_nxt[j]   = s03_r[j] + s12_r[j];
      sd_nxt[j]   = s03_r[j] - s12_r[j];

      dif5_nxt[j] = t0_r[j] - t1_r[j];
      sm5_nxt[j]  = t0_r[j] + t1_r[j];
      o0_5_nxt[j] = qmul(ss_r[j], dct8_pkg::K_QUARTER);
      o2_5_nxt[j] = qmul(sd_r[j], dct8_pkg::K_QUARTER);

      m6_nxt[j]   = qmul(sm5_r[j], dct8_pkg::K_SQRT2);
      dif6_nxt[j] = dif5_r[j];
      o0_6_nxt[j] = o0_5_r[j];
      o2_6_nxt[j] = o2_5_r[j];
    end
    // odd half: first value scaled by sqrt2
    mf0_6_nxt = qmul(o0_5_r[1], dct8_pkg::K_SQRT2);

    e7_nxt[0] = o0_6_r[0];
    e7_nxt[1] = m6_r[0] + dif6_r[0];
    e7_nxt[2] = o2_6_r[0];
    e7_nxt[3] = dif6_r[0];
    f7_nxt[0] = o0_6_r[1];
    f7_nxt[1] = m6_r[1] + dif6_r[1];
    f7_nxt[2] = o2_6_r[1];
    f7_nxt[3] = dif6_r[1];
    mf0_7_nxt = mf0_6_r;

    // stage 8: interleave, odd outputs from neighbor sums
    y_nxt[0] = e7_r[0];
    y_nxt[2] = e7_r[1];
    y_nxt[4] = e7_r[2];
    y_nxt[6] = e7_r[3];
    y_nxt[1] = mf0_7_r + f7_r[1];
    y_nxt[3] = f7_r[1] + f7_r[2];
    y_nxt[5] = f7_r[2] + f7_r[3];
    y_nxt[7] = f7_r[3];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ps_r    <= ps_nxt;
    pd_r    <= pd_nxt;
    g_r     <= g_nxt;
    s03_r   <= s03_nxt;
    s12_r   <= s12_nxt;
    d03_r   <= d03_nxt;
    d12_r   <= d12_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    ss_r    <= ss_nxt;
    sd_r    <= sd_nxt;
    dif5_r  <= dif5_nxt;
    sm5_r   <= sm5_nxt;
    o0_5_r  <= o0_5_nxt;
    o2_5_r  <= o2_5_nxt;
    m6_r    <= m6_nxt;
    dif6_r  <= dif6_nxt;
    o0_6_r  <= o0_6_nxt;
    o2_6_r  <= o2_6_nxt;
    mf0_6_r <= mf0_6_nxt;
    e7_r    <= e7_nxt;
    f7_r    <= f7_nxt;
    mf0_7_r <= mf0_7_nxt;
    y_r     <= y_nxt;
  end

  assign out_valid = vld_r[dct8_pkg::PIPE_DEPTH-1];
  assign y         = y_r;

endmodule

@@ hw/rtl/dct8_inv.sv @@
`timescale 1ns / 1ps

// Inverse 8-point DCT path, eight register stages, one beat per cycle.
module dct8_inv #(
  parameter int IW = dct8_pkg::SAMPLE_BITS_DEF + dct8_pkg::GUARD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] x [8],
  output logic                 out_valid,
  output logic signed [IW-1:0] y [8]
);

  localparam int PW = IW + dct8_pkg::KW + 1;

  // constant multiply, floor((v*c + half) / 2^14)
  function automatic logic signed [IW-1:0] qmul(input logic signed [IW-1:0] v,
                                                input logic [dct8_pkg::KW-1:0] c);
    logic signed [PW-1:0] p;
    p = PW'(v) * PW'($signed({1'b0, c}));
    p = p + PW'(dct8_pkg::Q_ROUND);
    return p[IW+dct8_pkg::Q_FRAC-1:dct8_pkg::Q_FRAC];
  endfunction

  logic [dct8_pkg::PIPE_DEPTH-1:0] vld_r;

  logic signed [IW-1:0] x_r [8], x_nxt [8];
  logic signed [IW-1:0] g_r [8], g_nxt [8];
  logic signed [IW-1:0] t0_r [2], t0_nxt [2];
  logic signed [IW-1:0] t1_r [2], t1_nxt [2];
  logic signed [IW-1:0] s3_r [2], s3_nxt [2];
  logic signed [IW-1:0] d3_r [2], d3_nxt [2];
  logic signed [IW-1:0] u_r [2], u_nxt [2];
  logic signed [IW-1:0] v_r [2], v_nxt [2];
  logic signed [IW-1:0] s4_r [2], s4_nxt [2];
  logic signed [IW-1:0] d4_r [2], d4_nxt [2];
  logic signed [IW-1:0] p_r [2], p_nxt [2];
  logic signed [IW-1:0] q_r [2], q_nxt [2];
  logic signed [IW-1:0] s5_r [2], s5_nxt [2];
  logic signed [IW-1:0] d5_r [2], d5_nxt [2];
  logic signed [IW-1:0] h_r [8], h_nxt [8];
  logic signed [IW-1:0] e7_r [4], e7_nxt [4];
  logic signed [IW-1:0] r7_r [4], r7_nxt [4];
  logic signed [IW-1:0] y_r [8], y_nxt [8];

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[dct8_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_comb begin
    // stage 1: input register
    x_nxt = x;
    // stage 2: evens pass; odds take neighbor sums, but x1 is sqrt2-scaled
    g_nxt[0] = x_r[0];
    g_nxt[1] = x_r[2];
    g_nxt[2] = x_r[4];
    g_nxt[3] = x_r[6];
    g_nxt[4] = qmul(x_r[1], dct8_pkg::K_SQRT2);
    g_nxt[5] = x_r[3] + x_r[1];
    g_nxt[6] = x_r[5] + x_r[3];
    g_nxt[7] = x_r[7] + x_r[5];
    // stages 3 to 6: two inverse 4-point transforms side by side
    for (int j = 0; j < 2; j++) begin
      t0_nxt[j] = qmul(g_r[4*j+1], dct8_pkg::K_SQRT2);
      t1_nxt[j] = g_r[4*j+1] + g_r[4*j+3];
      s3_nxt[j] = g_r[4*j] + g_r[4*j+2];
      d3_nxt[j] = g_r[4*j] - g_r[4*j+2];

      u_nxt[j]  = t0_r[j] + t1_r[j];
      v_nxt[j]  = t0_r[j] - t1_r[j];
      s4_nxt[j] = s3_r[j];
      d4_nxt[j] = d3_r[j];

      p_nxt[j]  = qmul(u_r[j], dct8_pkg::K_I4_SEC0);
      q_nxt[j]  = qmul(v_r[j], dct8_pkg::K_I4_SEC1);
      s5_nxt[j] = s4_r[j];
      d5_nxt[j] = d4_r[j];

      h_nxt[4*j]   = s5_r[j] + p_r[j];
      h_nxt[4*j+1] = d5_r[j] + q_r[j];
      h_nxt[4*j+2] = d5_r[j] - q_r[j];
      h_nxt[4*j+3] = s5_r[j] - p_r[j];
    end
    // stage 7: secant weights on the odd half
    for (int i = 0; i < 4; i++) begin
      e7_nxt[i] = h_r[i];
      r7_nxt[i] = qmul(h_r[4+i], dct8_pkg::SEC_INV[i]);
    end
    // stage 8: butterfly combine
    for (int i = 0; i < 4; i++) begin
      y_nxt[i]   = e7_r[i] + r7_r[i];
      y_nxt[7-i] = e7_r[i] - r7_r[i];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    g_r  <= g_nxt;
    t0_r <= t0_nxt;
    t1_r <= t1_nxt;
    s3_r <= s3_nxt;
    d3_r <= d3_nxt;
    u_r  <= u_nxt;
    v_r  <= v_nxt;
    s4_r <= s4_nxt;
    d4_r <= d4_nxt;
    p_r  <= p_nxt;
    q_r  <= q_nxt;
    s5_r <= s5_nxt;
    d5_r <= d5_nxt;
    h_r  <= h_nxt;
    e7_r <= e7_nxt;
    r7_r <= r7_nxt;
    y_r  <= y_nxt;
  end

  assign out_valid = vld_r[dct8_pkg::PIPE_DEPTH-1];
  assign y         = y_r;

endmodule

@@ hw/rtl/dct8_forward_inverse_core.sv @@
`timescale 1ns / 1ps

// channel   | ports                         | beat taken when
// ----------+-------------------------------+-------------------------------
// input     | start, busy, in_mode, in_0..7 | start high, busy low
// result    | out_valid, out_0..out_7       | every cycle out_valid is high
//
// One beat is taken every cycle; busy stays low. A result passes eight
// stages in the forward or inverse path, each but the inverse input register
// closing a constant multiply or an add, then the saturating output register.
// Both paths have the same depth, so results leave in input order.
// Reset (synchronous, rst_n low) clears the valid bits only; no result is
// produced for a beat dropped by reset. The receiver cannot stall.
module dct8_forward_inverse_core #(
  parameter int SAMPLE_BITS = dct8_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic signed [SAMPLE_BITS-1:0] in_0,
  input  logic signed [SAMPLE_BITS-1:0] in_1,
  input  logic signed [SAMPLE_BITS-1:0] in_2,
  input  logic signed [SAMPLE_BITS-1:0] in_3,
  input  logic signed [SAMPLE_BITS-1:0] in_4,
  input  logic signed [SAMPLE_BITS-1:0] in_5,
  input  logic signed [SAMPLE_BITS-1:0] in_6,
  input  logic signed [SAMPLE_BITS-1:0] in_7,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_0,
  output logic signed [SAMPLE_BITS-1:0] out_1,
  output logic signed [SAMPLE_BITS-1:0] out_2,
  output logic signed [SAMPLE_BITS-1:0] out_3,
  output logic signed [SAMPLE_BITS-1:0] out_4,
  output logic signed [SAMPLE_BITS-1:0] out_5,
  output logic signed [SAMPLE_BITS-1:0] out_6,
  output logic signed [SAMPLE_BITS-1:0] out_7
);

  localparam int IW = SAMPLE_BITS + dct8_pkg::GUARD_BITS;

  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] smp [8];
  logic signed [IW-1:0]          xw [8];
  logic                          fwd_vld, inv_vld;
  logic signed [IW-1:0]          fwd_y [8], inv_y [8];
  logic signed [IW-1:0]          ysel;
  logic signed [SAMPLE_BITS-1:0] res_nxt [8], res_r [8];
  logic                          vld_nxt, vld_r;

  // fully pipelined, never holds off a beat
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign smp[0] = in_0;
  assign smp[1] = in_1;
  assign smp[2] = in_2;
  assign smp[3] = in_3;
  assign smp[4] = in_4;
  assign smp[5] = in_5;
  assign smp[6] = in_6;
  assign smp[7] = in_7;

  // sign-extend into datapath width
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      xw[i] = {{dct8_pkg::GUARD_BITS{smp[i][SAMPLE_BITS-1]}}, smp[i]};
    end
  end

  dct8_fwd #(.IW(IW)) u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept && !in_mode),
    .x         (xw),
    .out_valid (fwd_vld),
    .y         (fwd_y)
  );

  dct8_inv #(.IW(IW)) u_inv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept && in_mode),
    .x         (xw),
    .out_valid (inv_vld),
    .y         (inv_y)
  );

  // pick the live path, then saturate to the sample width
  always_comb begin
    ysel = '0;
    for (int i = 0; i < 8; i++) begin
      ysel = fwd_vld ? fwd_y[i] : inv_y[i];
      if ((&ysel[IW-1:SAMPLE_BITS-1]) || !(|ysel[IW-1:SAMPLE_BITS-1])) begin
        res_nxt[i] = ysel[SAMPLE_BITS-1:0];
      end else begin
        res_nxt[i] = {ysel[IW-1], {(SAMPLE_BITS-1){~ysel[IW-1]}}};
      end
    end
    vld_nxt = fwd_vld || inv_vld;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_0     = res_r[0];
  assign out_1     = res_r[1];
  assign out_2     = res_r[2];
  assign out_3     = res_r[3];
  assign out_4     = res_r[4];
  assign out_5     = res_r[5];
  assign out_6     = res_r[6];
  assign out_7     = res_r[7];

endmodule
